// ===== hdl/tcdcd_pkg.sv =====
// shared types, constants and display tables for the three-coil detector
`default_nettype none
package tcdcd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int BAR_LEDS   = 16;
    localparam int NUM_COILS  = 3;

    localparam int CODE_W   = 12;
    localparam int MV_W     = 10;
    localparam int CFG_W    = 10;
    localparam int CNT_W    = 4;
    localparam int SEG_W    = 8;
    localparam int AN_W     = 4;
    localparam int POS_W    = 2;
    localparam int CFG_IDX_W = 3;

    // mv = floor(code * 61 / 250), done as code * (61 * ceil(2^34 / 250)) >> 34
    localparam int          MV_SHIFT = 34;
    localparam logic [31:0] MV_RECIP = 32'd4191888097;
    localparam int          MV_PROD_W = CODE_W + 32;

    // floor(d / 6) = d * 2731 >> 14, exact for d below 1365
    localparam int          DIV6_SHIFT = 14;
    localparam logic [11:0] DIV6_RECIP = 12'd2731;

    localparam logic [SEG_W-1:0] DP_MASK     = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
    localparam logic [AN_W-1:0]  ANODE_BLANK = 4'hF;

    localparam logic [CFG_W-1:0] RST_LEFT_THR   = 10'd120;
    localparam logic [CFG_W-1:0] RST_CENTER_THR = 10'd190;
    localparam logic [CFG_W-1:0] RST_RIGHT_THR  = 10'd60;
    localparam logic [CFG_W-1:0] RST_BLINK_PER  = 10'd1000;
    localparam logic [CFG_W-1:0] RST_BLANK_LIM  = 10'd300;

    typedef enum logic [1:0] {
        COIL_LEFT   = 2'd0,
        COIL_CENTER = 2'd1,
        COIL_RIGHT  = 2'd2
    } t_coil;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_THR   = 3'd0,
        CFG_CENTER_THR = 3'd1,
        CFG_RIGHT_THR  = 3'd2,
        CFG_BLINK_PER  = 3'd3,
        CFG_BLANK_LIM  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic                hit;
        logic [BAR_LEDS-1:0] bar;
    } t_lane_res;

    // first member sits in the top bits
    typedef struct packed {
        logic                right_hit;
        logic                center_hit;
        logic                left_hit;
        logic [BAR_LEDS-1:0] led_bar;
        logic [SEG_W-1:0]    segments;
        logic [AN_W-1:0]     anodes;
    } t_result;

    function automatic logic [SEG_W-1:0] seg_of(input logic [CNT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'h0: s = 8'hC0;
            4'h1: s = 8'hF9;
            4'h2: s = 8'hA4;
            4'h3: s = 8'hB0;
            4'h4: s = 8'h99;
            4'h5: s = 8'h92;
            4'h6: s = 8'h82;
            4'h7: s = 8'hF8;
            4'h8: s = 8'h80;
            4'h9: s = 8'h90;
            4'hA: s = 8'h88;
            4'hB: s = 8'h83;
            4'hC: s = 8'hC6;
            4'hD: s = 8'hA1;
            4'hE: s = 8'h86;
            4'hF: s = 8'h8E;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [AN_W-1:0] anode_of(input logic [POS_W-1:0] p);
        logic [AN_W-1:0] a;
        unique case (p)
            2'd0: a = 4'h7;
            2'd1: a = 4'hB;
            2'd2: a = 4'hD;
            2'd3: a = 4'hE;
            default: a = ANODE_BLANK;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/three_coil_detect_count_display.sv =====
// top level: stream ports, configuration registers, lane pipeline control
`default_nettype none
// Three-coil metal detector front end. Each request on the input stream carries
// three 12-bit coil codes; each produces exactly one result request holding the
// digit enables and segments for one step of the four-digit scan, the 16-LED
// proximity bar and the three hit flags. Three coil lanes work side by side
// (millivolt scaling, then threshold compare and bar), and a merge stage keeps
// the hit counts, digit patterns, scan position and blink counter. Each request
// goes through the lane millivolt, lane result and merge result registers; one
// request is taken every cycle while the output side keeps up, and empty pipeline
// stages keep taking requests while a result waits. The configuration port is
// always ready and should only be written while no request is in flight.
module three_coil_detect_count_display
    import tcdcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // [11:0] left_code, [23:12] center_code, [35:24] right_code, [39:36] zero
    input  wire logic [39:0]          s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [3:0] anodes, [11:4] segments, [27:12] led_bar, [28] left_hit,
    // [29] center_hit, [30] right_hit, [31] zero
    output logic [31:0]               m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_thr [NUM_COILS];
    logic [CFG_W-1:0] r_blink_period;
    logic [CFG_W-1:0] r_blank_limit;

    logic r_v1, r_v2, r_ov;
    logic w_en1, w_en2, w_eno;

    t_lane_res w_lane [NUM_COILS];
    t_result   w_result;

    // bubble-collapsing advance, each stage moves when the next is free
    assign w_eno = !r_ov || m_axis_tready;
    assign w_en2 = !r_v2 || w_eno;
    assign w_en1 = !r_v1 || w_en2;

    assign s_axis_tready = w_en1;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_eno) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[COIL_LEFT]   <= RST_LEFT_THR;
            r_thr[COIL_CENTER] <= RST_CENTER_THR;
            r_thr[COIL_RIGHT]  <= RST_RIGHT_THR;
            r_blink_period     <= RST_BLINK_PER;
            r_blank_limit      <= RST_BLANK_LIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_THR:   r_thr[COIL_LEFT]   <= i_cfg_data;
                CFG_CENTER_THR: r_thr[COIL_CENTER] <= i_cfg_data;
                CFG_RIGHT_THR:  r_thr[COIL_RIGHT]  <= i_cfg_data;
                CFG_BLINK_PER:  r_blink_period     <= i_cfg_data;
                CFG_BLANK_LIM:  r_blank_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcdcd_lane #(.COIL(COIL_LEFT)) u_lane_left (
        .i_clk  (i_clk),
        .i_en1  (w_en1),
        .i_en2  (w_en2),
        .i_code (s_axis_tdata[11:0]),
        .i_thr  (r_thr[COIL_LEFT]),
        .o_res  (w_lane[COIL_LEFT])
    );

    tcdcd_lane #(.COIL(COIL_CENTER)) u_lane_center (
        .i_clk  (i_clk),
        .i_en1  (w_en1),
        .i_en2  (w_en2),
        .i_code (s_axis_tdata[23:12]),
        .i_thr  (r_thr[COIL_CENTER]),
        .o_res  (w_lane[COIL_CENTER])
    );

    tcdcd_lane #(.COIL(COIL_RIGHT)) u_lane_right (
        .i_clk  (i_clk),
        .i_en1  (w_en1),
        .i_en2  (w_en2),
        .i_code (s_axis_tdata[35:24]),
        .i_thr  (r_thr[COIL_RIGHT]),
        .o_res  (w_lane[COIL_RIGHT])
    );

    tcdcd_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (r_v2 && w_eno),
        .i_lane         (w_lane),
        .i_blink_period (r_blink_period),
        .i_blank_limit  (r_blank_limit),
        .o_result       (w_result)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, w_result};

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted request lost at stage one");

    // a held stage keeps its request
    a_stage2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_eno) |=> r_v2)
        else $error("stage two request dropped while stalled");

    // at most one digit enabled at a time
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(~w_result.anodes) <= 1))
        else $error("more than one digit enabled");

    // the OR of thermometer codes is itself a thermometer code
    a_bar_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_result.led_bar & (w_result.led_bar + 16'd1)) == 16'd0))
        else $error("led bar is not a thermometer code");

endmodule
`default_nettype wire

// ===== hdl/tcdcd_lane.sv =====
// one coil lane: code to millivolts, hit compare and proximity bar
`default_nettype none
module tcdcd_lane
    import tcdcd_pkg::*;
#(
    parameter t_coil COIL = COIL_LEFT
) (
    input  wire logic              i_clk,
    input  wire logic              i_en1,
    input  wire logic              i_en2,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic [CFG_W-1:0]  i_thr,
    output t_lane_res              o_res
);

    logic [MV_PROD_W-1:0] w_prod;
    logic [MV_W-1:0]      r_mv;
    logic [MV_W-1:0]      w_drop;
    logic [MV_W-1:0]      w_quot;
    logic [21:0]          w_div6;
    logic                 w_hit;
    logic [BAR_LEDS-1:0]  w_bar;
    t_lane_res            r_res;

    assign w_prod = {32'd0, i_code} * {12'd0, MV_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_mv <= w_prod[MV_SHIFT +: MV_W];
        end
    end

    assign w_drop = (i_thr > r_mv) ? (i_thr - r_mv) : '0;
    assign w_div6 = {12'd0, w_drop} * {10'd0, DIV6_RECIP};

    always_comb begin
        unique case (COIL)
            COIL_LEFT: begin
                w_hit  = (r_mv < i_thr);
                w_quot = {2'd0, w_div6[DIV6_SHIFT +: 8]};
            end
            COIL_CENTER: begin
                w_hit  = (r_mv < i_thr);
                w_quot = {2'd0, w_drop[MV_W-1:2]};
            end
            COIL_RIGHT: begin
                w_hit  = (r_mv > i_thr);
                w_quot = {1'b0, w_drop[MV_W-1:1]};
            end
            default: begin
                w_hit  = 1'b0;
                w_quot = '0;
            end
        endcase
    end

    // thermometer code, full bar once the quotient reaches the led count
    assign w_bar = (w_quot >= MV_W'(BAR_LEDS)) ? '1
                 : ((BAR_LEDS'(1) << w_quot[3:0]) - BAR_LEDS'(1));

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_res.hit <= w_hit;
            r_res.bar <= w_bar;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== hdl/tcdcd_merge.sv =====
// merge stage: hit counting, digit patterns, scan and blink, result register
`default_nettype none
module tcdcd_merge
    import tcdcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire t_lane_res        i_lane [NUM_COILS],
    input  wire logic [CFG_W-1:0] i_blink_period,
    input  wire logic [CFG_W-1:0] i_blank_limit,
    output t_result               o_result
);

    localparam logic [POS_W-1:0] LAST_DIGIT = POS_W'(NUM_DIGITS - 1);

    logic [NUM_COILS-1:0] r_flags;
    logic [CNT_W-1:0]     r_coil [NUM_COILS];
    logic [CNT_W-1:0]     r_total;
    logic [SEG_W-1:0]     r_pat  [NUM_DIGITS];
    logic [POS_W-1:0]     r_pos;
    logic [CFG_W-1:0]     r_blink;
    t_result              r_res;

    logic [NUM_COILS-1:0] w_now;
    logic [NUM_COILS-1:0] w_rise;
    logic [CNT_W-1:0]     n_coil [NUM_COILS];
    logic [CNT_W-1:0]     n_total;
    logic [SEG_W-1:0]     n_pat  [NUM_DIGITS];
    logic [CFG_W-1:0]     w_blink_inc;
    logic [CFG_W-1:0]     n_blink;
    logic [BAR_LEDS-1:0]  w_bar;
    t_result              n_res;

    always_comb begin
        for (int i = 0; i < NUM_COILS; i++) begin
            w_now[i] = i_lane[i].hit;
        end
        w_rise  = w_now & ~r_flags;
        for (int i = 0; i < NUM_COILS; i++) begin
            n_coil[i] = r_coil[i] + CNT_W'(w_rise[i]);
        end
        n_total = r_total + CNT_W'(w_rise[COIL_LEFT]) + CNT_W'(w_rise[COIL_CENTER])
                + CNT_W'(w_rise[COIL_RIGHT]);

        // digit order on the display: left, center, right, total
        n_pat[0] = seg_of(n_total);
        n_pat[1] = seg_of(n_coil[COIL_RIGHT])  & (w_now[COIL_RIGHT]  ? DP_MASK : SEG_BLANK);
        n_pat[2] = seg_of(n_coil[COIL_CENTER]) & (w_now[COIL_CENTER] ? DP_MASK : SEG_BLANK);
        n_pat[3] = seg_of(n_coil[COIL_LEFT])   & (w_now[COIL_LEFT]   ? DP_MASK : SEG_BLANK);

        w_blink_inc = r_blink + CFG_W'(1);
        n_blink     = (w_blink_inc == i_blink_period) ? '0 : w_blink_inc;

        w_bar = i_lane[COIL_LEFT].bar | i_lane[COIL_CENTER].bar | i_lane[COIL_RIGHT].bar;

        n_res.anodes     = (r_blink <= i_blank_limit) ? ANODE_BLANK : anode_of(r_pos);
        n_res.segments   = r_pat[LAST_DIGIT - r_pos];
        n_res.led_bar    = w_bar;
        n_res.left_hit   = w_now[COIL_LEFT];
        n_res.center_hit = w_now[COIL_CENTER];
        n_res.right_hit  = w_now[COIL_RIGHT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_total <= '0;
            r_pos   <= '0;
            r_blink <= '0;
            for (int i = 0; i < NUM_COILS; i++) begin
                r_coil[i] <= '0;
            end
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_pat[i] <= SEG_BLANK;
            end
        end else if (i_take) begin
            r_flags <= w_now;
            r_total <= n_total;
            r_pos   <= r_pos + POS_W'(1);
            r_blink <= n_blink;
            for (int i = 0; i < NUM_COILS; i++) begin
                r_coil[i] <= n_coil[i];
            end
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_pat[i] <= n_pat[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule
`default_nettype wire
